FILE: src/tlcs_pkg.sv
// Shared types and constants for the two-lane traffic cell step block.
`timescale 1ns / 1ps
package tlcs_pkg;

    typedef enum logic [1:0] {
        MODE_PLACE  = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_MOVE   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ROLE_ONLY     = 2'd0,
        ROLE_FIRST    = 2'd1,
        ROLE_INTERIOR = 2'd2,
        ROLE_LAST     = 2'd3
    } role_t;

    localparam logic [2:0] ADDR_SPEED_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_LOOK_BACK   = 3'd1;
    localparam logic [2:0] ADDR_SLOW_THR    = 3'd2;
    localparam logic [2:0] ADDR_CHANGE_THR  = 3'd3;
    localparam logic [2:0] ADDR_ROLE        = 3'd4;

    typedef struct packed {
        logic [3:0]  speed_limit;
        logic [7:0]  look_back;
        logic [15:0] slow_threshold;
        logic [15:0] change_threshold;
        role_t       segment_role;
    } cfg_t;

    // One queued item, as classified by the front end.
    typedef struct packed {
        mode_t       mode;
        logic        lane;
        logic [9:0]  position;
        logic [3:0]  speed;
        logic [15:0] trip_steps;
        logic        change_ok;   // rand_change <= change_threshold
        logic        slow_hit;    // rand_slow <= slow_threshold
        logic [9:0]  edge_own;
        logic [9:0]  edge_oth_f;
        logic [9:0]  edge_oth_b;
    } job_t;

    typedef struct packed {
        logic        new_lane;
        logic [10:0] moved_site;
        logic [3:0]  new_speed;
        logic [15:0] new_time;
        logic [10:0] gap_ahead;
        logic [11:0] gap_ahead_other;
        logic [11:0] gap_behind_other;
        logic        switched;
        logic        exited;
    } res_t;

endpackage

FILE: src/tlcs_front.sv
// Front end: input acceptance, random-draw compares and a two-entry job queue.
`timescale 1ns / 1ps
module tlcs_front
    import tlcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  in_mode,
    input  logic        in_lane,
    input  logic [9:0]  in_position,
    input  logic [3:0]  in_speed,
    input  logic [15:0] in_time,
    input  logic [15:0] in_rand_change,
    input  logic [15:0] in_rand_slow,
    input  logic [9:0]  in_edge_own,
    input  logic [9:0]  in_edge_oth_f,
    input  logic [9:0]  in_edge_oth_b,
    output logic        job_valid,
    input  logic        job_take,
    output job_t        job
);

    job_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    job_t       in_job;
    logic       push;

    always_comb begin
        in_job.mode         = mode_t'(in_mode);
        in_job.lane         = in_lane;
        in_job.position     = in_position;
        in_job.speed        = in_speed;
        in_job.trip_steps   = in_time;
        in_job.change_ok    = (in_rand_change <= cfg.change_threshold);
        in_job.slow_hit     = (in_rand_slow <= cfg.slow_threshold);
        in_job.edge_own     = in_edge_own;
        in_job.edge_oth_f   = in_edge_oth_f;
        in_job.edge_oth_b   = in_edge_oth_b;
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= in_job;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (job_take) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, job_take};
        end
    end

endmodule

FILE: src/tlcs_back.sv
// Back end: occupancy memory, word-wise gap scans, move and write-back.
`timescale 1ns / 1ps
module tlcs_back
    import tlcs_pkg::*;
#(
    parameter int LANE_SITES = 1024
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic job_valid,
    output logic job_take,
    input  job_t job,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int WORD  = 16;
    localparam int NWORD = (LANE_SITES + WORD - 1) / WORD;
    localparam int WA    = (NWORD > 1) ? $clog2(NWORD) : 1;
    localparam int MA    = WA + 1;
    localparam int CW    = $clog2(NWORD + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SCAN_A, S_SCAN_F, S_SCAN_B, S_DECIDE,
        S_WR_NEW_RD, S_WR_NEW, S_WR_OLD_RD, S_WR_OLD, S_OUT
    } state_t;

    // Memory: one row of WORD sites, address {lane, word}.
    logic [WORD-1:0] mem [2*NWORD];
    logic [WORD-1:0] rd_data_reg;
    logic [MA-1:0]   rd_addr;
    logic            rd_en;
    logic [MA-1:0]   wr_addr;
    logic [WORD-1:0] wr_data;
    logic            wr_en;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    state_t          state_reg;
    job_t            job_reg;
    logic [MA-1:0]   clr_reg;
    logic [WA-1:0]   word_reg;
    logic [CW-1:0]   left_reg;      // rows still to read in this scan
    logic            pend_reg;      // a read result is present
    logic [WA-1:0]   pword_reg;     // word of the pending read
    logic [11:0]     ga_reg, gf_reg, gb_reg;
    logic [3:0]      sp_reg;
    logic [16:0]     np_reg;
    logic            sw_reg, ex_reg;
    logic            set_reg;       // old-site write sets rather than clears
    logic [15:0]     tm_reg;
    res_t            res_reg;
    logic            res_valid_reg;

    localparam logic [16:0] SITES = 17'(LANE_SITES);

    logic [WA-1:0] pos_word;
    logic [3:0]    pos_bit;
    assign pos_word = WA'(job_reg.position >> 4);
    assign pos_bit  = job_reg.position[3:0];
    logic          pos_in;
    assign pos_in   = ({7'd0, job_reg.position} < SITES);

    // masked row bits for scan direction
    logic [WORD-1:0] row, mrow;
    logic [4:0]      fidx, lidx;
    logic            any;
    logic [16:0]     site_base;
    always_comb begin
        row = rd_data_reg;
        for (int i = 0; i < WORD; i++)
            if ({pword_reg, 4'(i)} >= SITES[WA+3:0] && (NWORD * WORD != LANE_SITES))
                row[i] = 1'b0;
        mrow = row;
        if (pword_reg == pos_word) begin
            for (int i = 0; i < WORD; i++) begin
                if (state_reg == S_SCAN_A && 4'(i) <= pos_bit) mrow[i] = 1'b0;
                if (state_reg == S_SCAN_F && 4'(i) <  pos_bit) mrow[i] = 1'b0;
                if (state_reg == S_SCAN_B && 4'(i) >  pos_bit) mrow[i] = 1'b0;
            end
        end
        fidx = 5'd0;
        for (int i = WORD - 1; i >= 0; i--) if (mrow[i]) fidx = 5'(i);
        lidx = 5'd0;
        for (int i = 0; i < WORD; i++) if (mrow[i]) lidx = 5'(i);
        any = |mrow;
        site_base = 17'({pword_reg, 4'd0});
    end

    logic [16:0] posx;
    assign posx = {7'd0, job_reg.position};

    function automatic logic [11:0] capg(input logic [17:0] v);
        capg = (v > 18'd2047) ? 12'd2047 : v[11:0];
    endfunction

    // Fallback gaps when no vehicle is found.
    logic [17:0] nf_ahead, nf_fwd, nf_back, tail;
    logic        not_last, interior;
    always_comb begin
        interior = (cfg.segment_role == ROLE_INTERIOR);
        not_last = (cfg.segment_role == ROLE_FIRST) || interior;
        tail     = (posx + 17'd1 > SITES) ? 18'd0 : {1'b0, SITES - posx - 17'd1};
        nf_ahead = (not_last ? tail : {1'b0, SITES - 17'd1}) + 18'(job_reg.edge_own);
        nf_fwd   = (interior ? tail : {1'b0, SITES - 17'd1}) + 18'(job_reg.edge_oth_f);
        nf_back  = (interior ? {1'b0, posx} : {1'b0, SITES - 17'd1})
                   + 18'(job_reg.edge_oth_b);
    end

    // Decision arithmetic.
    logic [4:0]  look, spd1;
    logic        do_change;
    logic [3:0]  sp_a, sp_b;
    always_comb begin
        look = 5'(job_reg.speed) + 5'd1;
        do_change = (ga_reg < 12'(look)) && ($signed(gf_reg) > $signed(12'(look)))
                    && ($signed(gb_reg) > $signed({4'd0, cfg.look_back}))
                    && job_reg.change_ok;
        spd1 = (job_reg.speed != cfg.speed_limit && job_reg.speed != 4'd15)
               ? look : 5'(job_reg.speed);
        sp_a = (ga_reg < 12'(spd1)) ? ga_reg[3:0] : spd1[3:0];
        sp_b = (sp_a != 4'd0 && job_reg.slow_hit) ? sp_a - 4'd1 : sp_a;
    end

    logic          scan_st;
    assign scan_st = (state_reg == S_SCAN_A) || (state_reg == S_SCAN_F)
                     || (state_reg == S_SCAN_B);
    logic [WA-1:0] np_word;
    assign np_word = WA'(np_reg >> 4);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {job_reg.lane, pos_word};
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        job_take = 1'b0;
        unique case (state_reg)
            S_CLEAR: wr_en = 1'b1;
            S_SCAN_A: begin
                rd_en   = (left_reg != '0) && !(pend_reg && any);
                rd_addr = {job_reg.lane, word_reg};
            end
            S_SCAN_F, S_SCAN_B: begin
                rd_en   = (left_reg != '0) && !(pend_reg && any);
                rd_addr = {~job_reg.lane, word_reg};
            end
            S_WR_NEW_RD: begin
                rd_en   = 1'b1;
                rd_addr = {sw_reg ? ~job_reg.lane : job_reg.lane,
                           sw_reg ? pos_word : np_word};
            end
            S_WR_NEW: begin
                wr_en   = 1'b1;
                wr_addr = {sw_reg ? ~job_reg.lane : job_reg.lane,
                           sw_reg ? pos_word : np_word};
                wr_data = rd_data_reg;
                wr_data[sw_reg ? pos_bit : np_reg[3:0]] = 1'b1;
            end
            S_WR_OLD_RD: begin
                rd_en   = 1'b1;
                rd_addr = {job_reg.lane, pos_word};
            end
            S_WR_OLD: begin
                wr_en   = 1'b1;
                wr_addr = {job_reg.lane, pos_word};
                wr_data = rd_data_reg;
                wr_data[pos_bit] = set_reg;
            end
            S_IDLE: job_take = job_valid;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            if (scan_st) begin
                pend_reg <= rd_en;
                if (rd_en) begin
                    pword_reg <= word_reg;
                    left_reg  <= left_reg - CW'(1);
                    word_reg  <= (state_reg == S_SCAN_B) ? word_reg - WA'(1)
                                                         : word_reg + WA'(1);
                end
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + MA'(1);
                    if (clr_reg == MA'(2 * NWORD - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job;
                        sw_reg  <= 1'b0;
                        ex_reg  <= 1'b0;
                        ga_reg <= '0; gf_reg <= '0; gb_reg <= '0;
                        sp_reg <= job.speed;
                        tm_reg <= job.trip_steps;
                        np_reg <= {7'd0, job.position};
                        pend_reg <= 1'b0;
                        word_reg <= WA'(job.position >> 4);
                        left_reg <= ({7'd0, job.position} < SITES)
                                    ? CW'(NWORD - (job.position >> 4)) : '0;
                        unique case (job.mode)
                            MODE_PLACE: begin
                                set_reg   <= 1'b1;
                                state_reg <= ({7'd0, job.position} < SITES)
                                             ? S_WR_OLD_RD : S_OUT;
                            end
                            MODE_CHANGE, MODE_MOVE: state_reg <= S_SCAN_A;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_SCAN_A, S_SCAN_F, S_SCAN_B: begin
                    if ((pend_reg && any) || (!pend_reg && left_reg == '0)) begin
                        if (state_reg == S_SCAN_A)
                            ga_reg <= (pend_reg && any)
                                ? 12'(site_base + 17'(fidx) - posx - 17'd1)
                                : capg(nf_ahead);
                        else if (state_reg == S_SCAN_F)
                            gf_reg <= (pend_reg && any)
                                ? 12'(site_base + 17'(fidx) - posx - 17'd1)
                                : capg(nf_fwd);
                        else
                            gb_reg <= (pend_reg && any)
                                ? 12'(posx - site_base - 17'(lidx) - 17'd1)
                                : capg(nf_back);
                        pend_reg <= 1'b0;
                        word_reg <= pos_word;
                        if (state_reg == S_SCAN_A) begin
                            left_reg  <= pos_in ? CW'(NWORD - 32'(pos_word)) : '0;
                            state_reg <= S_SCAN_F;
                        end else if (state_reg == S_SCAN_F) begin
                            left_reg  <= pos_in ? CW'(32'(pos_word) + 1) : '0;
                            state_reg <= S_SCAN_B;
                        end else begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    set_reg <= 1'b0;
                    if (job_reg.mode == MODE_CHANGE) begin
                        if (do_change && pos_in) begin
                            sw_reg    <= 1'b1;
                            state_reg <= S_WR_NEW_RD;
                        end else begin
                            sw_reg    <= do_change;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        tm_reg <= (job_reg.trip_steps != 16'hFFFF)
                                  ? job_reg.trip_steps + 16'd1 : job_reg.trip_steps;
                        sp_reg <= sp_b;
                        state_reg <= (sp_b != 4'd0) ? S_WR_NEW_RD : S_OUT;
                        np_reg <= posx + 17'(sp_b);
                        ex_reg <= (sp_b != 4'd0) && (posx + 17'(sp_b) >= SITES);
                    end
                end
                S_WR_NEW_RD: begin
                    if (!sw_reg && ex_reg) state_reg <= pos_in ? S_WR_OLD_RD : S_OUT;
                    else state_reg <= S_WR_NEW;
                end
                S_WR_NEW: state_reg <= pos_in ? S_WR_OLD_RD : S_OUT;
                S_WR_OLD_RD: state_reg <= S_WR_OLD;
                S_WR_OLD: state_reg <= S_OUT;
                S_OUT: begin
                    if (!res_valid_reg || res_ready) begin
                        res_valid_reg         <= 1'b1;
                        res_reg.new_lane      <= sw_reg ? ~job_reg.lane : job_reg.lane;
                        res_reg.moved_site    <= np_reg[10:0];
                        res_reg.new_speed     <= sp_reg;
                        res_reg.new_time      <= tm_reg;
                        res_reg.gap_ahead     <= ga_reg[10:0];
                        res_reg.gap_ahead_other  <= gf_reg;
                        res_reg.gap_behind_other <= gb_reg;
                        res_reg.switched      <= sw_reg;
                        res_reg.exited        <= ex_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: src/two_lane_traffic_cell_step.sv
// Top level of the two-lane traffic cell step block.
`timescale 1ns / 1ps
// Two-lane cellular traffic automaton for one road segment. Each s_ transfer
// names one vehicle and a mode (place, lane-change phase, move phase); each
// produces exactly one m_ transfer. Occupancy lives in a RAM of 16-site rows,
// one port, so a phase item scans its own lane ahead, the other lane ahead and
// the other lane behind one row per cycle, stopping at the first vehicle; an
// item is taken, scanned, decided, written back, and its result registered.
// After reset the RAM is swept clear before the first item is taken;
// configuration writes are accepted meanwhile. A two-entry queue sits
// between input and scan engine, and the result register frees the engine
// while a result waits.
module two_lane_traffic_cell_step
    import tlcs_pkg::*;
#(
    parameter int LANE_SITES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], lane[2], position[12:3], speed[16:13], trip_steps[32:17],
    // rand_change[48:33], rand_slow[64:49], edge_gap_ahead_own[74:65],
    // edge_gap_ahead_other[84:75], edge_gap_behind_other[94:85]; zero pad
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_lane[0], moved_site[11:1], new_speed[15:12], new_time[31:16],
    // gap_ahead[42:32], gap_ahead_other[54:43], gap_behind_other[66:55],
    // switched[67], exited[68]; zero pad
    output logic [71:0]  m_tdata
);

    cfg_t cfg_reg;
    logic wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_limit      <= 4'd5;
            cfg_reg.look_back        <= 8'd3;
            cfg_reg.slow_threshold   <= 16'd0;
            cfg_reg.change_threshold <= 16'hFFFF;
            cfg_reg.segment_role     <= ROLE_ONLY;
        end else if (wr) begin
            unique case (paddr[4:2])
                ADDR_SPEED_LIMIT: cfg_reg.speed_limit      <= pwdata[3:0];
                ADDR_LOOK_BACK:   cfg_reg.look_back        <= pwdata[7:0];
                ADDR_SLOW_THR:    cfg_reg.slow_threshold   <= pwdata[15:0];
                ADDR_CHANGE_THR:  cfg_reg.change_threshold <= pwdata[15:0];
                ADDR_ROLE:        cfg_reg.segment_role     <= role_t'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            ADDR_SPEED_LIMIT: prdata = {28'd0, cfg_reg.speed_limit};
            ADDR_LOOK_BACK:   prdata = {24'd0, cfg_reg.look_back};
            ADDR_SLOW_THR:    prdata = {16'd0, cfg_reg.slow_threshold};
            ADDR_CHANGE_THR:  prdata = {16'd0, cfg_reg.change_threshold};
            ADDR_ROLE:        prdata = {30'd0, cfg_reg.segment_role};
            default:          prdata = 32'd0;
        endcase
    end

    logic job_valid, job_take;
    job_t job;
    res_t res;

    tlcs_front u_front (
        .aclk, .aresetn, .cfg(cfg_reg),
        .s_tvalid, .s_tready,
        .in_mode(s_tdata[1:0]), .in_lane(s_tdata[2]), .in_position(s_tdata[12:3]),
        .in_speed(s_tdata[16:13]), .in_time(s_tdata[32:17]),
        .in_rand_change(s_tdata[48:33]), .in_rand_slow(s_tdata[64:49]),
        .in_edge_own(s_tdata[74:65]), .in_edge_oth_f(s_tdata[84:75]),
        .in_edge_oth_b(s_tdata[94:85]),
        .job_valid, .job_take, .job
    );

    tlcs_back #(.LANE_SITES(LANE_SITES)) u_back (
        .aclk, .aresetn, .cfg(cfg_reg),
        .job_valid, .job_take, .job,
        .res_valid(m_tvalid), .res_ready(m_tready), .res
    );

    assign m_tdata = {3'd0, res.exited, res.switched, res.gap_behind_other,
                      res.gap_ahead_other, res.gap_ahead, res.new_time,
                      res.new_speed, res.moved_site, res.new_lane};

    logic unused_ok;
    assign unused_ok = ^{s_tdata[95], paddr[1:0]};

endmodule

FILE: src/tlcs_checker.sv
// Port-level checks for the two-lane traffic cell step block, with bind.
`timescale 1ns / 1ps
module tlcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[67] && m_tdata[68]))
        else $error("switched and exited together");
    a_exit_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[68] |-> m_tdata[11])
        else $error("exit without position past segment");
    a_ready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind two_lane_traffic_cell_step tlcs_checker u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .pready
);

FILE: tb/sv/tb_two_lane_traffic_cell_step.sv
// Self-checking testbench for the two-lane traffic cell step block.
`timescale 1ns / 1ps
module tb_two_lane_traffic_cell_step;
    import tlcs_pkg::*;

    localparam int SITES = 1024;

    // One vehicle command as it travels on s_tdata
    typedef struct {
        mode_t       mode;
        bit          lane;
        bit [9:0]    pos;
        bit [3:0]    spd;
        bit [15:0]   tim;
        bit [15:0]   rc;
        bit [15:0]   rs;
        bit [9:0]    eo;
        bit [9:0]    ef;
        bit [9:0]    eb;
    } veh_cmd_t;

    // A vehicle the stimulus keeps driving through the phases
    typedef struct {
        bit lane;
        int pos;
        int spd;
        int tim;
    } vehicle_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [71:0] m_tdata;

    two_lane_traffic_cell_step uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Clock: 12 ns period
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Predictor state: occupancy bitmap and a shadow of the registers
    bit [SITES-1:0] occ [2];
    int    cfg_speed_limit = 5;
    int    cfg_look_back   = 3;
    int    cfg_slow_thr    = 0;
    int    cfg_change_thr  = 65535;
    role_t cfg_role        = ROLE_ONLY;

    veh_cmd_t pending_cmds [$];   // commands waiting for the driver
    res_t     expected_res [$];   // predicted results, oldest first
    vehicle_t fleet [$];
    int       errors    = 0;
    int       idle_mode = 2;      // 0: sender light, 1: sender heavy, 2: no idling
    bit       hold      = 1'b0;   // sender pause requested by the stimulus

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int cap2047(int v);
        return (v > 2047) ? 2047 : v;
    endfunction

    // Free sites ahead in own lane, ahead and behind in the other lane
    function automatic void scan_gaps(input bit ln, input int p, input int eo,
                                      input int ef, input int eb,
                                      output int ga, output int gao, output int gbo);
        bit interior;
        bit not_last;
        bit found;
        int g;
        interior = (cfg_role == ROLE_INTERIOR);
        not_last = (cfg_role == ROLE_FIRST) || interior;

        found = 0;
        g = SITES - 1;
        for (int i = p + 1; i < SITES && !found; i++) begin
            if (occ[ln][i]) begin
                g = i - p - 1;
                found = 1;
            end
        end
        if (!found) begin
            if (not_last) g = (SITES - p - 1 < 0) ? 0 : SITES - p - 1;
            g += eo;
        end
        ga = cap2047(g);

        // other lane includes the site alongside, so an occupied neighbor reads -1
        found = 0;
        g = SITES - 1;
        for (int i = p; i < SITES && !found; i++) begin
            if (occ[!ln][i]) begin
                g = i - p - 1;
                found = 1;
            end
        end
        if (!found) begin
            if (interior) g = (SITES - p - 1 < 0) ? 0 : SITES - p - 1;
            g += ef;
        end
        gao = cap2047(g);

        found = 0;
        g = SITES - 1;
        for (int i = p; i >= 0 && !found; i--) begin
            if (occ[!ln][i]) begin
                g = p - i - 1;
                found = 1;
            end
        end
        if (!found) begin
            if (interior) g = p;
            g += eb;
        end
        gbo = cap2047(g);
    endfunction

    // Applies one command to the shadow road and returns its result
    function automatic res_t step_vehicle(veh_cmd_t c);
        res_t r;
        int   ga, gao, gbo;
        int   sp, np, tim, spd;
        ga = 0;
        gao = 0;
        gbo = 0;
        np = c.pos;
        tim = c.tim;
        spd = c.spd;
        r = '0;
        r.new_lane = c.lane;
        case (c.mode)
            MODE_PLACE: begin
                occ[c.lane][c.pos] = 1'b1;
            end
            MODE_CHANGE: begin
                scan_gaps(c.lane, c.pos, c.eo, c.ef, c.eb, ga, gao, gbo);
                if (ga < spd + 1 && gao > spd + 1 && gbo > cfg_look_back &&
                    c.rc <= cfg_change_thr) begin
                    occ[!c.lane][c.pos] = 1'b1;
                    occ[c.lane][c.pos] = 1'b0;
                    r.new_lane = !c.lane;
                    r.switched = 1'b1;
                end
            end
            MODE_MOVE: begin
                scan_gaps(c.lane, c.pos, c.eo, c.ef, c.eb, ga, gao, gbo);
                if (tim < 65535) tim++;
                if (spd != cfg_speed_limit && spd < 15) spd++;
                sp = (ga < spd) ? ga : spd;
                if (sp > 0 && c.rs <= cfg_slow_thr) sp--;
                if (sp > 0) begin
                    np = c.pos + sp;
                    // past the end: the old site is cleared, nothing is set
                    if (np >= SITES) begin
                        r.exited = 1'b1;
                    end else begin
                        occ[c.lane][np] = 1'b1;
                    end
                    occ[c.lane][c.pos] = 1'b0;
                end
                spd = sp;
            end
            default: ;  // unused mode leaves everything alone
        endcase
        r.moved_site       = np[10:0];
        r.new_speed        = spd[3:0];
        r.new_time         = tim[15:0];
        r.gap_ahead        = ga[10:0];
        r.gap_ahead_other  = gao[11:0];
        r.gap_behind_other = gbo[11:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one transfer per accepted command
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int sender_idle;
        sender_idle = (idle_mode == 0) ? 17 : (idle_mode == 1) ? 68 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cmds.size() != 0 && !hold && $urandom_range(99) >= sender_idle) begin
                veh_cmd_t c;
                c = pending_cmds.pop_front();
                s_tdata  <= {1'b0, c.eb, c.ef, c.eo, c.rs, c.rc, c.tim, c.spd, c.pos,
                             c.lane, c.mode};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure and field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int recv_idle;
        res_t want;
        recv_idle = (idle_mode == 0) ? 68 : (idle_mode == 1) ? 17 : 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_res.pop_front();
                    if (m_tdata[0] !== want.new_lane) begin
                        $error("new_lane exp %0d got %0d", want.new_lane, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[11:1] !== want.moved_site) begin
                        $error("moved_site exp %0d got %0d", want.moved_site,
                               m_tdata[11:1]);
                        errors++;
                    end
                    if (m_tdata[15:12] !== want.new_speed) begin
                        $error("new_speed exp %0d got %0d", want.new_speed, m_tdata[15:12]);
                        errors++;
                    end
                    if (m_tdata[31:16] !== want.new_time) begin
                        $error("new_time exp %0d got %0d", want.new_time, m_tdata[31:16]);
                        errors++;
                    end
                    if (m_tdata[42:32] !== want.gap_ahead) begin
                        $error("gap_ahead exp %0d got %0d", want.gap_ahead, m_tdata[42:32]);
                        errors++;
                    end
                    if (m_tdata[54:43] !== want.gap_ahead_other) begin
                        $error("gap_ahead_other exp %0d got %0d",
                               $signed(want.gap_ahead_other), $signed(m_tdata[54:43]));
                        errors++;
                    end
                    if (m_tdata[66:55] !== want.gap_behind_other) begin
                        $error("gap_behind_other exp %0d got %0d",
                               $signed(want.gap_behind_other), $signed(m_tdata[66:55]));
                        errors++;
                    end
                    if (m_tdata[67] !== want.switched) begin
                        $error("switched exp %0d got %0d", want.switched, m_tdata[67]);
                        errors++;
                    end
                    if (m_tdata[68] !== want.exited) begin
                        $error("exited exp %0d got %0d", want.exited, m_tdata[68]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic res_t queue_cmd(veh_cmd_t c);
        res_t r;
        r = step_vehicle(c);
        expected_res.push_back(r);
        pending_cmds.push_back(c);
        return r;
    endfunction

    function automatic veh_cmd_t make_cmd(mode_t m, bit ln, int p, int s, int t);
        veh_cmd_t c;
        c.mode = m;
        c.lane = ln;
        c.pos  = 10'(p);
        c.spd  = 4'(s);
        c.tim  = 16'(t);
        c.rc   = 16'($urandom_range(65535));
        c.rs   = 16'($urandom_range(65535));
        c.eo   = 10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(20));
        c.ef   = 10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(20));
        c.eb   = 10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(20));
        return c;
    endfunction

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_res.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register updates at its end
    task automatic reg_write(logic [2:0] idx, int value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ADDR_SPEED_LIMIT: cfg_speed_limit = value & 4'hF;
            ADDR_LOOK_BACK:   cfg_look_back   = value & 8'hFF;
            ADDR_SLOW_THR:    cfg_slow_thr    = value & 16'hFFFF;
            ADDR_CHANGE_THR:  cfg_change_thr  = value & 16'hFFFF;
            default:          cfg_role        = role_t'(value & 2'h3);
        endcase
    endtask

    task automatic set_config(int ms, int lb, int st, int ct, role_t ro);
        reg_write(ADDR_SPEED_LIMIT, ms);
        reg_write(ADDR_LOOK_BACK, lb);
        reg_write(ADDR_SLOW_THR, st);
        reg_write(ADDR_CHANGE_THR, ct);
        reg_write(ADDR_ROLE, ro);
    endtask

    // Mostly well-formed traffic: vehicles are placed, then driven through
    // lane-change and move phases; a slice is random noise
    task automatic traffic_phase(int n);
        veh_cmd_t c;
        res_t r;
        vehicle_t v;
        int k, idx, anchor;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 12 && fleet.size() < 48 || fleet.size() == 0) begin
                // new vehicle, half the time near the traffic already there
                anchor = (fleet.size() != 0 && $urandom_range(1)) ?
                         fleet[$urandom_range(fleet.size() - 1)].pos : $urandom_range(1023);
                anchor = anchor + $urandom_range(8) - 4;
                if (anchor < 0) anchor = 0;
                if (anchor > 1023) anchor = 1023;
                v.lane = 1'($urandom_range(1));
                v.pos  = anchor;
                v.spd  = $urandom_range(15);
                v.tim  = ($urandom_range(9) == 0) ? 65535 - $urandom_range(2)
                                                  : $urandom_range(65535);
                c = make_cmd(MODE_PLACE, v.lane, v.pos, v.spd, v.tim);
                r = queue_cmd(c);
                fleet.push_back(v);
            end else if (k < 92) begin
                idx = $urandom_range(fleet.size() - 1);
                v = fleet[idx];
                c = make_cmd($urandom_range(1) ? MODE_MOVE : MODE_CHANGE,
                             v.lane, v.pos, v.spd, v.tim);
                if ($urandom_range(7) == 0) c.rc = 16'(cfg_change_thr);
                if ($urandom_range(7) == 0) c.rs = 16'(cfg_slow_thr);
                r = queue_cmd(c);
                if (r.exited) begin
                    fleet.delete(idx);
                end else begin
                    fleet[idx].lane = r.new_lane;
                    fleet[idx].pos  = r.moved_site;
                    fleet[idx].spd  = r.new_speed;
                    fleet[idx].tim  = r.new_time;
                end
            end else begin
                c = make_cmd(mode_t'($urandom_range(3)), 1'($urandom_range(1)),
                             $urandom_range(1023), $urandom_range(15),
                             $urandom_range(65535));
                c.eo = 10'($urandom_range(1023));
                c.ef = 10'($urandom_range(1023));
                c.eb = 10'($urandom_range(1023));
                r = queue_cmd(c);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        veh_cmd_t c;
        res_t r;
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset configuration (only segment, max speed 5)
        idle_mode = 0;
        c = make_cmd(MODE_PLACE, 0, 0, 0, 0);            r = queue_cmd(c);
        c = make_cmd(MODE_PLACE, 1, 1023, 15, 65535);    r = queue_cmd(c);
        c = make_cmd(MODE_PLACE, 0, 3, 2, 10);           r = queue_cmd(c);
        c = make_cmd(MODE_PLACE, 1, 0, 1, 1);            r = queue_cmd(c);
        // vehicle alongside in the other lane: both other-lane gaps read -1
        c = make_cmd(MODE_CHANGE, 0, 0, 4, 7);           r = queue_cmd(c);
        // blocked ahead, other lane clear: lane change with draw at threshold
        c = make_cmd(MODE_PLACE, 0, 600, 3, 5);          r = queue_cmd(c);
        c = make_cmd(MODE_PLACE, 0, 601, 0, 0);          r = queue_cmd(c);
        c = make_cmd(MODE_CHANGE, 0, 600, 3, 5);
        c.rc = 16'hFFFF;  c.eo = 0;  c.ef = 1023;  c.eb = 1023;
        r = queue_cmd(c);
        // speed above max_speed, time saturating
        c = make_cmd(MODE_MOVE, 0, 3, 15, 65535);        r = queue_cmd(c);
        // move at the segment end: exits
        c = make_cmd(MODE_MOVE, 1, 1023, 4, 65534);
        c.eo = 1023;
        r = queue_cmd(c);
        c = make_cmd(MODE_MOVE, 0, 601, 0, 0);           r = queue_cmd(c);
        c = make_cmd(MODE_NONE, 1, 512, 9, 1234);        r = queue_cmd(c);
        c = make_cmd(MODE_PLACE, 1, 1000, 0, 0);
        c.rc = 0;  c.rs = 0;  c.eo = 0;  c.ef = 0;  c.eb = 0;
        r = queue_cmd(c);
        drain();

        // first segment, everything slows, nothing changes lane
        set_config(1, 0, 65535, 0, ROLE_FIRST);
        c = make_cmd(MODE_MOVE, 1, 1000, 1, 3);          r = queue_cmd(c);
        c = make_cmd(MODE_CHANGE, 1, 0, 0, 0);           r = queue_cmd(c);
        drain();
        // interior segment, fastest, strictest look-back
        set_config(15, 255, 0, 65535, ROLE_INTERIOR);
        c = make_cmd(MODE_MOVE, 0, 600, 14, 0);          r = queue_cmd(c);
        c = make_cmd(MODE_CHANGE, 1, 500, 0, 0);         r = queue_cmd(c);
        c = make_cmd(MODE_MOVE, 1, 1010, 15, 0);         r = queue_cmd(c);
        drain();

        // Random traffic across several register settings
        for (int ph = 0; ph < 8; ph++) begin
            idle_mode = (ph < 3) ? 0 : (ph < 6) ? 1 : 2;
            if (ph == 0)      set_config(15, 0, 0, 65535, ROLE_ONLY);
            else if (ph == 1) set_config(1, 255, 65535, 0, ROLE_LAST);
            else              set_config($urandom_range(1, 15), $urandom_range(12),
                                         $urandom_range(65535), $urandom_range(65535),
                                         role_t'($urandom_range(3)));
            traffic_phase(60);
            // sender holds until the block has returned everything
            if (ph == 4) begin
                while (pending_cmds.size() != 0) @(posedge aclk);
                hold = 1'b1;
                while (expected_res.size() != 0) @(posedge aclk);
                hold = 1'b0;
            end
            traffic_phase(60);
            drain();
        end

        repeat (250) @(posedge aclk);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("PASS two_lane_traffic_cell_step");
        end else begin
            $display("FAIL two_lane_traffic_cell_step");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("FAIL two_lane_traffic_cell_step");
        $finish;
    end

endmodule
